@@ src/sensor_frame_crc_decoder_macros.svh @@
// ----------------------------------------------------------------------------
// sensor_frame_crc_decoder_macros.svh
// Assertion macros used by the frame decoder checker
// ----------------------------------------------------------------------------
`ifndef SENSOR_FRAME_CRC_DECODER_MACROS_SVH
`define SENSOR_FRAME_CRC_DECODER_MACROS_SVH

// property that is checked only outside reset
`define SFCD_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("sfcd assertion failed");

// property that is also checked while reset is applied
`define SFCD_ASSERT_RST(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("sfcd reset assertion failed");

`endif

@@ src/sfcd_pkg.sv @@
// ----------------------------------------------------------------------------
// sfcd_pkg
// Types, constants and helper functions of the sensor frame decoder
// ----------------------------------------------------------------------------
package sfcd_pkg;

  // crc-8 settings, msb first, no reflection, no final xor
  localparam logic [7:0] CRC_INIT = 8'hFF;
  localparam logic [7:0] CRC_POLY = 8'h31;

  // conversion scale factors, full scale of a raw word is 65535
  localparam logic [14:0] TEMP_SPAN   = 15'd17500;
  localparam logic [14:0] TEMP_OFFSET = 15'd4500;
  localparam logic [13:0] HUM_SPAN    = 14'd10000;
  localparam logic [16:0] WORD_FULL   = 17'd65535;

  // position of the next byte within the six byte frame
  typedef enum logic [5:0] {
    POS_T_HI  = 6'b000001,
    POS_T_LO  = 6'b000010,
    POS_T_CRC = 6'b000100,
    POS_H_HI  = 6'b001000,
    POS_H_LO  = 6'b010000,
    POS_H_CRC = 6'b100000
  } pos_t;

  // completed frame handed from the assembler to the scaling stages
  typedef struct packed {
    logic        failed;
    logic [15:0] temp_code;
    logic [15:0] hum_code;
  } frame_t;

  // one byte through the crc-8 shift register
  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int b = 0; b < 8; b++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

  // floor(x / 65535) for x below 2^31: fold the high half back, one correction
  function automatic logic [15:0] div_word_full(input logic [30:0] x);
    logic [14:0] q0;
    logic [16:0] r;
    q0 = x[30:16];
    r  = 17'(x[15:0]) + 17'(q0);
    if (r >= WORD_FULL) begin
      return 16'(q0) + 16'd1;
    end else begin
      return 16'(q0);
    end
  endfunction

endpackage

@@ src/sfcd_frame.sv @@
// ----------------------------------------------------------------------------
// sfcd_frame
// Byte position tracking, word assembly and crc-8 checking of one frame
// ----------------------------------------------------------------------------
module sfcd_frame (
  input  logic            clk,
  input  logic            rst,
  input  logic            take,
  input  logic [7:0]      rx_byte,
  input  logic            frame_start,
  output logic            done,
  output sfcd_pkg::frame_t frame
);
  import sfcd_pkg::*;

  pos_t        pos, pos_eff, pos_next;
  logic [7:0]  running_crc, running_crc_next;
  logic [15:0] temp_word, temp_word_next;
  logic [15:0] hum_word, hum_word_next;
  logic        crc_failed, crc_failed_next;
  logic        crc_match;

  assign crc_match = (running_crc == rx_byte);

  // frame start or a stray position restarts at the first byte
  always_comb begin
    if (frame_start) begin
      pos_eff = POS_T_HI;
    end else begin
      unique case (pos)
        POS_T_HI, POS_T_LO, POS_T_CRC,
        POS_H_HI, POS_H_LO, POS_H_CRC: pos_eff = pos;
        default:                        pos_eff = POS_T_HI;
      endcase
    end
  end

  // per byte update of the frame state
  always_comb begin
    pos_next         = pos_eff;
    running_crc_next = running_crc;
    temp_word_next   = temp_word;
    hum_word_next    = hum_word;
    crc_failed_next  = crc_failed;
    unique case (pos_eff)
      POS_T_HI: begin
        crc_failed_next  = 1'b0;
        temp_word_next   = {rx_byte, 8'h00};
        running_crc_next = crc8_update(CRC_INIT, rx_byte);
        pos_next         = POS_T_LO;
      end
      POS_T_LO: begin
        temp_word_next   = {temp_word[15:8], rx_byte};
        running_crc_next = crc8_update(running_crc, rx_byte);
        pos_next         = POS_T_CRC;
      end
      POS_T_CRC: begin
        crc_failed_next  = crc_failed | ~crc_match;
        running_crc_next = CRC_INIT;
        pos_next         = POS_H_HI;
      end
      POS_H_HI: begin
        hum_word_next    = {rx_byte, 8'h00};
        running_crc_next = crc8_update(CRC_INIT, rx_byte);
        pos_next         = POS_H_LO;
      end
      POS_H_LO: begin
        hum_word_next    = {hum_word[15:8], rx_byte};
        running_crc_next = crc8_update(running_crc, rx_byte);
        pos_next         = POS_H_CRC;
      end
      POS_H_CRC: begin
        crc_failed_next  = crc_failed | ~crc_match;
        running_crc_next = CRC_INIT;
        pos_next         = POS_T_HI;
      end
      default: begin
        pos_next = POS_T_HI;
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pos         <= POS_T_HI;
      running_crc <= CRC_INIT;
      temp_word   <= '0;
      hum_word    <= '0;
      crc_failed  <= 1'b0;
    end else if (take) begin
      pos         <= pos_next;
      running_crc <= running_crc_next;
      temp_word   <= temp_word_next;
      hum_word    <= hum_word_next;
      crc_failed  <= crc_failed_next;
    end
  end

  // last crc byte completes the frame
  assign done            = take && (pos_eff == POS_H_CRC);
  assign frame.failed    = crc_failed | ~crc_match;
  assign frame.temp_code = temp_word;
  assign frame.hum_code  = hum_word;

endmodule

@@ src/sfcd_scale.sv @@
// ----------------------------------------------------------------------------
// sfcd_scale
// Two stage conversion of raw words to centi units with the output register
// ----------------------------------------------------------------------------
module sfcd_scale (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    load,
  input  sfcd_pkg::frame_t        frame,
  output logic                    busy,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic                    status,
  output logic signed [14:0]      temperature_centi,
  output logic [13:0]             humidity_centi
);
  import sfcd_pkg::*;

  logic        mid_valid;
  logic        mid_failed;
  logic [30:0] temp_prod;
  logic [30:0] hum_prod;
  logic        out_load;
  logic [15:0] temp_quot;
  logic [15:0] hum_quot;

  // output slot is free or being emptied
  assign out_load = mid_valid && (!out_valid || !out_stall);
  assign busy     = mid_valid && out_valid && out_stall;

  // product stage
  always_ff @(posedge clk) begin
    if (rst) begin
      mid_valid <= 1'b0;
    end else if (load) begin
      mid_valid <= 1'b1;
    end else if (out_load) begin
      mid_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      mid_failed <= frame.failed;
      temp_prod  <= 31'(frame.temp_code) * 31'(TEMP_SPAN);
      hum_prod   <= 31'(frame.hum_code) * 31'(HUM_SPAN);
    end
  end

  // divide by full scale
  assign temp_quot = div_word_full(temp_prod);
  assign hum_quot  = div_word_full(hum_prod);

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      status <= mid_failed;
      if (mid_failed) begin
        temperature_centi <= '0;
        humidity_centi    <= '0;
      end else begin
        temperature_centi <= $signed(15'(temp_quot) - TEMP_OFFSET);
        humidity_centi    <= 14'(hum_quot);
      end
    end
  end

endmodule

@@ src/sensor_frame_crc_decoder.sv @@
// ----------------------------------------------------------------------------
// sensor_frame_crc_decoder
// CRC-8 checking and unit conversion of a six byte temperature/humidity frame
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid, in_stall, rx_byte, frame_start) takes one frame
//   byte per transfer: temperature high, low, crc, humidity high, low, crc.
//   frame_start marks byte 0 and drops any partial frame.
//   Output channel (out_valid, out_stall) carries one result per frame:
//   status, temperature_centi, humidity_centi. On a crc failure status is 1
//   and both values read 0.
//   The product register loads at the transfer edge of the last crc byte;
//   the result register loads from it once the output slot is free or being
//   emptied, and out_valid rises with the result register.
//   Throughput: one byte per cycle while in_stall is low.
//   While the receiver stalls, the result holds and one more finished frame
//   waits in the product stage; in_stall rises only when both are full, and
//   then holds off every byte, not only the last one of a frame.
//   Reset (rst, synchronous) returns to byte 0 with the crc at 0xFF and
//   empties both result stages.
// ----------------------------------------------------------------------------
module sensor_frame_crc_decoder (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         rx_byte,
  input  logic               frame_start,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               status,
  output logic signed [14:0] temperature_centi,
  output logic [13:0]        humidity_centi
);
  import sfcd_pkg::*;

  logic   take;
  logic   done;
  logic   busy;
  frame_t frame;

  // byte accepted on this edge
  assign take     = in_valid && !in_stall;
  assign in_stall = busy;

  // frame assembly and crc check
  sfcd_frame u_frame (
    .clk         (clk),
    .rst         (rst),
    .take        (take),
    .rx_byte     (rx_byte),
    .frame_start (frame_start),
    .done        (done),
    .frame       (frame)
  );

  // conversion and output register
  sfcd_scale u_scale (
    .clk               (clk),
    .rst               (rst),
    .load              (done),
    .frame             (frame),
    .busy              (busy),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .status            (status),
    .temperature_centi (temperature_centi),
    .humidity_centi    (humidity_centi)
  );

endmodule

@@ src/sfcd_checker.sv @@
// ----------------------------------------------------------------------------
// sfcd_checker
// Port level assertions for the sensor frame decoder, bound to the top level
// ----------------------------------------------------------------------------
`include "sensor_frame_crc_decoder_macros.svh"

module sfcd_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic               status,
  input logic signed [14:0] temperature_centi,
  input logic [13:0]        humidity_centi
);

  // a failed frame carries zero values
  `SFCD_ASSERT(a_fail_zero, out_valid && status |-> temperature_centi == 15'sd0 && humidity_centi == 14'd0)

  // a good frame stays inside the conversion range
  `SFCD_ASSERT(a_range, out_valid && !status |-> temperature_centi >= -15'sd4500 && temperature_centi <= 15'sd13000 && humidity_centi <= 14'd10000)

  // a stalled result is held
  `SFCD_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(status) && $stable(temperature_centi) && $stable(humidity_centi))

  // input backs up only behind a stalled result
  `SFCD_ASSERT(a_stall_full, in_stall |-> out_valid && out_stall)

  // reset empties the output
  `SFCD_ASSERT_RST(a_rst_empty, rst |=> !out_valid)

endmodule

bind sensor_frame_crc_decoder sfcd_checker u_sfcd_checker (.*);
